/* design/sorted_table_binary_search_top_defines.svh */
// Assertion macros shared by the sorted table binary search design.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sts check failed");

// The consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sts check failed");

`endif

/* design/sts_pkg.sv */
// Package of the sorted table binary search: sizes, operation codes,
// controller states and the command and status structs. Depends on nothing.
package sts_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned OpW        = 2;
  localparam int unsigned IndexW     = 10;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic append;
    logic clear;
    logic start;
    logic probe;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic range_empty;
    logic hit;
    logic out_free;
  } status_t;

endpackage

/* design/sts_if.sv */
// Handshake channels of the sorted table binary search: request and response.
// Depends on sts_pkg.
interface sts_req_if;
  import sts_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         operation;
  logic signed [KeyW-1:0] value;
  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface sts_rsp_if;
  import sts_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [IndexW-1:0] index;
  modport source (output valid, output found, output index, input ready);
  modport sink (input valid, input found, input index, output ready);
endinterface

/* design/sorted_table_binary_search_top.sv */
// Top level of the sorted table binary search.
// Depends on sts_pkg, sts_if, sts_ctrl and sts_datapath.
//
// Usage: requests arrive on req_i, one transaction per operation. Operation
// append stores value as the next table entry (ignored once the table holds
// TableDepth entries), clear empties the table, query searches for value, and
// the unused code is dropped. Only a query produces a response transaction on
// rsp_o, carrying found and the matching index (zero when not found).
// Appends and clears are done on acceptance; the block stays ready.
// A query runs a binary search: each probe is one registered read of the key
// memory followed by one signed compare. With n entries a query makes
// p <= floor(log2(n)) + 1 probes; a hit ends the search at once and a miss
// ends it when the search range is empty.
// The single-port key memory and the shared compare mean that one
// request is worked on at a time.
// A finished response sits in an output register, so a new request can be
// taken while rsp_o is stalled; a later query then waits at its end until the
// register is freed. Reset empties the table and drops any pending response;
// the key memory itself is not cleared, since only written entries are read.
module sorted_table_binary_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  sts_req_if.sink     req_i,
  sts_rsp_if.source   rsp_o
);
  import sts_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller sees only the opcode; the key goes straight to the datapath.
  sts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath owns the response register and its valid flag.
  sts_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (req_i.value),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .found_o     (rsp_o.found),
    .index_o     (rsp_o.index)
  );

endmodule

/* design/sts_datapath.sv */
// Datapath of the sorted table binary search: key memory, entry count,
// search bounds, compare and output register. Depends on sts_pkg and the defines.
`include "sorted_table_binary_search_top_defines.svh"

module sts_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sts_pkg::cmd_t                   cmd_i,
  output sts_pkg::status_t                status_o,
  input  logic signed [sts_pkg::KeyW-1:0] value_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            found_o,
  output logic [sts_pkg::IndexW-1:0]      index_o
);
  import sts_pkg::*;

  localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

  logic [KeyW-1:0]   mem [TableDepth];
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   low_q, hi_q;
  logic [KeyW-1:0]   key_q, rd_q;
  logic [IdxW-1:0]   mid_q, mid;
  logic [CntW:0]     mid_sum;
  logic              found_q;
  logic              out_valid_q;
  logic              out_found_q;
  logic [IndexW-1:0] out_index_q;
  logic              hit, key_lt, can_append;

  // Bounds are kept as [low, hi) so that both stay unsigned.
  assign mid_sum    = {1'b0, low_q} + {1'b0, hi_q} - (CntW + 1)'(1);
  assign mid        = IdxW'(mid_sum >> 1);
  assign hit        = (rd_q == key_q);
  assign key_lt     = $signed(rd_q) < $signed(key_q);
  assign can_append = (count_q < DepthCnt);

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.append && can_append) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && can_append) begin
      mem[count_q[IdxW-1:0]] <= value_i;
    end
    if (cmd_i.probe) begin
      rd_q  <= mem[mid];
      mid_q <= mid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q   <= value_i;
      low_q   <= '0;
      hi_q    <= count_q;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (hit) begin
        found_q <= 1'b1;
      end else if (key_lt) begin
        low_q <= CntW'(mid_q) + CntW'(1);
      end else begin
        hi_q <= CntW'(mid_q);
      end
    end
    if (cmd_i.load) begin
      out_found_q <= found_q;
      out_index_q <= found_q ? IndexW'(mid_q) : '0;
    end
  end

  assign status_o.range_empty = (low_q >= hi_q);
  assign status_o.hit         = hit;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign index_o     = out_index_q;

  `STS_ASSERT_SAME(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= DepthCnt)
  `STS_ASSERT_SAME(a_probe_in_range, clk_i, rst_ni, cmd_i.probe, low_q < hi_q)
  `STS_ASSERT_SAME(a_miss_index_zero, clk_i, rst_ni, out_valid_q && !out_found_q,
                   out_index_q == '0)
  `STS_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd_i.load, out_valid_q)

endmodule

/* design/sts_ctrl.sv */
// Controller of the sorted table binary search: decodes requests and steps
// the probe loop. Depends on sts_pkg and the defines.
`include "sorted_table_binary_search_top_defines.svh"

module sts_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic [sts_pkg::OpW-1:0]   req_op_i,
  output logic                      req_ready_o,
  input  sts_pkg::status_t          status_i,
  output sts_pkg::cmd_t             cmd_o
);
  import sts_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && req_op_i == OP_QUERY) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        state_d = status_i.range_empty ? S_DONE : S_CMP;
      end
      S_CMP: begin
        state_d = status_i.hit ? S_DONE : S_PROBE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (accept) begin
          unique case (req_op_i)
            OP_APPEND: cmd_o.append = 1'b1;
            OP_QUERY:  cmd_o.start  = 1'b1;
            OP_CLEAR:  cmd_o.clear  = 1'b1;
            default:   cmd_o        = '0;
          endcase
        end
      end
      S_PROBE: cmd_o.probe = !status_i.range_empty;
      S_CMP:   cmd_o.step  = 1'b1;
      S_DONE:  cmd_o.load  = status_i.out_free;
      default: cmd_o       = '0;
    endcase
  end

  `STS_ASSERT_NEXT(a_load_to_idle, clk_i, rst_ni, cmd_o.load, state_q == S_IDLE)
  `STS_ASSERT_SAME(a_cmp_after_probe, clk_i, rst_ni, state_q == S_CMP,
                   $past(state_q) == S_PROBE)
  `STS_ASSERT_SAME(a_start_on_accept, clk_i, rst_ni, cmd_o.start,
                   req_valid_i && req_ready_o)

endmodule
